FILE: hdl/kwc_pkg.sv
package kwc_pkg;

    localparam int DATA_W  = 32;
    localparam int TAG_W   = 5;
    localparam int UNIT_W  = DATA_W + TAG_W;
    localparam int SLICE_W = 7;
    localparam int LAST_W  = UNIT_W - (UNIT_W / SLICE_W) * SLICE_W;
    localparam int SLICES  = (UNIT_W + SLICE_W - 1) / SLICE_W;
    localparam int SLICE_CNT_W = $clog2(SLICES);
    localparam int BITS_W  = $clog2(SLICE_W + 1);
    localparam int CFG_W   = 5;

    localparam logic [DATA_W-1:0] CRC_POLY = 32'h82F6_3B78;

    typedef logic [DATA_W-1:0] t_crc;
    typedef logic [UNIT_W-1:0] t_unit;

endpackage

FILE: hdl/kwc_key_if.sv
interface kwc_key_if;
    logic                        valid;
    logic                        ready;
    logic [kwc_pkg::DATA_W-1:0]  key_word;

    modport source (output valid, output key_word, input ready);
    modport sink   (input valid, input key_word, output ready);
endinterface

FILE: hdl/kwc_crc_if.sv
interface kwc_crc_if;
    logic                        valid;
    logic                        ready;
    logic [kwc_pkg::DATA_W-1:0]  crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

FILE: hdl/kwc_fold.sv
// folds up to one slice of bits, lsb first, into a reflected crc
module kwc_fold (
    input  kwc_pkg::t_crc                   i_crc,
    input  logic [kwc_pkg::SLICE_W-1:0]     i_bits,
    input  logic [kwc_pkg::BITS_W-1:0]      i_nbits,
    output kwc_pkg::t_crc                   o_crc
);

    always_comb begin
        kwc_pkg::t_crc c;
        c = i_crc;
        for (int b = 0; b < kwc_pkg::SLICE_W; b++) begin
            if (kwc_pkg::BITS_W'(b) < i_nbits) begin
                c[0] = c[0] ^ i_bits[b];
                if (c[0]) begin
                    c = (c >> 1) ^ kwc_pkg::CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
        end
        o_crc = c;
    end

endmodule

FILE: hdl/key_word_crc32c.sv
// Reflected CRC-32C (poly 0x82F63B78, init 0, no final xor) over KEY_WORDS
// 32-bit key words sent highest position first. Each word is folded as a
// 37-bit unit (data, then 5-bit position+1) by one shared 7-bit slice folder.
// A word is accepted and then folded slice by slice, and the
// input is not ready meanwhile. The first word of a run also folds pad_words
// zero units first. After the last word the CRC goes to an output register;
// the block waits there only if the previous result has not been taken yet.
// pad_words is sampled when the first word of a run is accepted.
module key_word_crc32c #(
    parameter int KEY_WORDS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kwc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    kwc_key_if.sink                     i_key,
    kwc_crc_if.source                   o_crc
);

    localparam int WCNT_W = 3;

    typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_KEY, ST_DONE} t_state;

    t_state                             r_state, n_state;
    kwc_pkg::t_crc                      r_crc, n_crc;
    kwc_pkg::t_unit                     r_unit, n_unit;
    logic [kwc_pkg::SLICE_CNT_W-1:0]    r_slice, n_slice;
    logic [kwc_pkg::CFG_W-1:0]          r_pad_n, n_pad_n;
    logic [kwc_pkg::CFG_W-1:0]          r_pad_cfg;
    logic [WCNT_W-1:0]                  r_words, n_words;
    logic [kwc_pkg::DATA_W-1:0]         r_word, n_word;
    logic                               r_out_valid, n_out_valid;
    kwc_pkg::t_crc                      r_out_crc, n_out_crc;

    kwc_pkg::t_crc                      w_fold;
    logic [kwc_pkg::BITS_W-1:0]         w_nbits;
    logic                               w_last_slice;
    logic                               w_slot_free;
    logic                               w_accept;

    function automatic logic [kwc_pkg::TAG_W-1:0] pad_tag(input logic [kwc_pkg::CFG_W-1:0] n);
        pad_tag = kwc_pkg::TAG_W'(KEY_WORDS + int'(n) + 1);
    endfunction

    function automatic logic [kwc_pkg::TAG_W-1:0] key_tag(input logic [WCNT_W-1:0] w);
        key_tag = kwc_pkg::TAG_W'(KEY_WORDS - int'(w));
    endfunction

    assign w_last_slice = (r_slice == kwc_pkg::SLICE_CNT_W'(kwc_pkg::SLICES - 1));
    assign w_nbits      = w_last_slice ? kwc_pkg::BITS_W'(kwc_pkg::LAST_W)
                                       : kwc_pkg::BITS_W'(kwc_pkg::SLICE_W);
    assign w_slot_free  = !r_out_valid || o_crc.ready;
    assign w_accept     = i_key.valid && i_key.ready;

    kwc_fold u_fold (
        .i_crc   (r_crc),
        .i_bits  (r_unit[kwc_pkg::SLICE_W-1:0]),
        .i_nbits (w_nbits),
        .o_crc   (w_fold)
    );

    always_comb begin
        n_state     = r_state;
        n_crc       = r_crc;
        n_unit      = r_unit;
        n_slice     = r_slice;
        n_pad_n     = r_pad_n;
        n_words     = r_words;
        n_word      = r_word;
        n_out_valid = r_out_valid && !o_crc.ready;
        n_out_crc   = r_out_crc;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_slice = '0;
                    n_word  = i_key.key_word;
                    if (r_words == '0 && r_pad_cfg != '0) begin
                        n_pad_n = r_pad_cfg - 1'b1;
                        n_unit  = {pad_tag(r_pad_cfg - 1'b1), {kwc_pkg::DATA_W{1'b0}}};
                        n_state = ST_PAD;
                    end else begin
                        n_unit  = {key_tag(r_words), i_key.key_word};
                        n_state = ST_KEY;
                    end
                end
            end
            ST_PAD: begin
                n_crc   = w_fold;
                n_unit  = r_unit >> kwc_pkg::SLICE_W;
                n_slice = r_slice + 1'b1;
                if (w_last_slice) begin
                    n_slice = '0;
                    if (r_pad_n == '0) begin
                        n_unit  = {key_tag(r_words), r_word};
                        n_state = ST_KEY;
                    end else begin
                        n_pad_n = r_pad_n - 1'b1;
                        n_unit  = {pad_tag(r_pad_n - 1'b1), {kwc_pkg::DATA_W{1'b0}}};
                    end
                end
            end
            ST_KEY: begin
                n_crc   = w_fold;
                n_unit  = r_unit >> kwc_pkg::SLICE_W;
                n_slice = r_slice + 1'b1;
                if (w_last_slice) begin
                    n_slice = '0;
                    if (r_words == WCNT_W'(KEY_WORDS - 1)) begin
                        n_words = '0;
                        if (w_slot_free) begin
                            n_out_valid = 1'b1;
                            n_out_crc   = w_fold;
                            n_crc       = '0;
                            n_state     = ST_IDLE;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_words = r_words + 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                // result waits here until the previous beat is taken
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_crc   = r_crc;
                    n_crc       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_crc       <= '0;
            r_slice     <= '0;
            r_pad_n     <= '0;
            r_pad_cfg   <= '0;
            r_words     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_slice     <= n_slice;
            r_pad_n     <= n_pad_n;
            r_words     <= n_words;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_pad_cfg <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit    <= n_unit;
        r_word    <= n_word;
        r_out_crc <= n_out_crc;
    end

    assign i_key.ready     = (r_state == ST_IDLE);
    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = r_out_crc;

    a_slice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slice <= kwc_pkg::SLICE_CNT_W'(kwc_pkg::SLICES - 1))
        else $error("slice counter out of range");

    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |-> r_out_valid)
        else $error("holding a result with a free output slot");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted beat not processed");

    a_words_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_words) < KEY_WORDS)
        else $error("word count out of range");

endmodule

FILE: tb/tb_top.sv
class key_crc_tracker;
    localparam int KEY_WORDS = 8;

    logic [kwc_pkg::DATA_W-1:0] crc_due[$];
    logic [kwc_pkg::DATA_W-1:0] run_crc;
    logic [kwc_pkg::CFG_W-1:0]  pad_cfg;
    int unsigned                words_in_run;
    int unsigned                words_seen;
    int unsigned                crcs_checked;
    int unsigned                errors;

    function new();
        run_crc      = '0;
        pad_cfg      = '0;
        words_in_run = 0;
        words_seen   = 0;
        crcs_checked = 0;
        errors       = 0;
    endfunction

    // one 37-bit unit, lsb first: data bits then the position tag
    function automatic logic [kwc_pkg::DATA_W-1:0] fold_unit(
        input logic [kwc_pkg::DATA_W-1:0] crc,
        input logic [kwc_pkg::DATA_W-1:0] data,
        input logic [kwc_pkg::TAG_W-1:0]  tag
    );
        logic [kwc_pkg::UNIT_W-1:0] unit;
        logic [kwc_pkg::DATA_W-1:0] acc;
        unit = {tag, data};
        acc  = crc;
        for (int b = 0; b < kwc_pkg::UNIT_W; b++) begin
            acc[0] = acc[0] ^ unit[b];
            if (acc[0]) begin
                acc = (acc >> 1) ^ kwc_pkg::CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    function void note_key_word(input logic [kwc_pkg::DATA_W-1:0] word);
        logic [kwc_pkg::TAG_W-1:0] tag;
        words_seen++;
        if (words_in_run == 0) begin
            // pad count is taken at the first word; tags wrap mod 32
            run_crc = '0;
            for (int k = int'(pad_cfg); k > 0; k--) begin
                run_crc = fold_unit(run_crc, '0, kwc_pkg::TAG_W'(KEY_WORDS + k));
            end
        end
        tag     = kwc_pkg::TAG_W'(KEY_WORDS - words_in_run);
        run_crc = fold_unit(run_crc, word, tag);
        if (words_in_run + 1 >= KEY_WORDS) begin
            crc_due.push_back(run_crc);
            run_crc      = '0;
            words_in_run = 0;
        end else begin
            words_in_run++;
        end
    endfunction

    function void check_crc(input logic [kwc_pkg::DATA_W-1:0] got);
        logic [kwc_pkg::DATA_W-1:0] want;
        crcs_checked++;
        if (crc_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] unexpected crc beat: got %08h", $time, got);
            end
        end else begin
            want = crc_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("[%0t] crc_value mismatch: expected %08h, got %08h",
                             $time, want, got);
                end
            end
        end
    endfunction

    function void flush_leftover();
        if (crc_due.size() != 0) begin
            $display("%0d crc results never arrived", crc_due.size());
            errors += crc_due.size();
            crc_due.delete();
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_WORDS  = 8;
    localparam int IDLE_PCT   = 8;
    localparam int SETTLE_CYC = 200;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [kwc_pkg::CFG_W-1:0]  i_cfg_wr_data;
    logic                       quiet;
    int unsigned                pad_writes;

    kwc_key_if key_if ();
    kwc_crc_if crc_if ();

    key_crc_tracker tracker;

    key_word_crc32c #(
        .KEY_WORDS (KEY_WORDS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_key         (key_if),
        .o_crc         (crc_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

    // result side stalls at random
    always @(negedge i_clk) begin
        crc_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && key_if.valid && key_if.ready) begin
            tracker.note_key_word(key_if.key_word);
        end
        if (i_rst_n && crc_if.valid && crc_if.ready) begin
            tracker.check_crc(crc_if.crc_value);
        end
    end

    function automatic logic [kwc_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return kwc_pkg::DATA_W'(1) << $urandom_range(kwc_pkg::DATA_W - 1);
            3: return ~(kwc_pkg::DATA_W'(1) << $urandom_range(kwc_pkg::DATA_W - 1));
            default: return $urandom;
        endcase
    endfunction

    // called and returns at a falling edge; valid stays high into the next call
    task automatic send_key_word(input logic [kwc_pkg::DATA_W-1:0] word);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            key_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        key_if.valid    <= 1'b1;
        key_if.key_word <= word;
        do @(posedge i_clk); while (!(key_if.valid && key_if.ready));
        @(negedge i_clk);
    endtask

    task automatic drain_crcs();
        while (tracker.crc_due.size() != 0) @(negedge i_clk);
        // a word may still be folding, with up to 31 pad units ahead of it
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_pad(input logic [kwc_pkg::CFG_W-1:0] pad);
        key_if.valid <= 1'b0;
        drain_crcs();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= pad;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.pad_cfg = pad;
        pad_writes++;
    endtask

    initial begin
        int unsigned n;
        logic [kwc_pkg::CFG_W-1:0] pad;

        tracker         = new();
        pad_writes      = 0;
        quiet           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        key_if.valid    = 1'b0;
        key_if.key_word = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset pad of zero, all-zero key
        for (int i = 0; i < KEY_WORDS; i++) send_key_word('0);

        // pad above range, then changed in the middle of a run
        write_pad(5'd31);
        for (int i = 0; i < 3; i++) send_key_word('1);
        write_pad(5'd1);
        for (int i = 0; i < 5; i++) send_key_word('1);

        send_key_word(32'h0000_0001);
        send_key_word(32'h8000_0000);
        send_key_word(32'hAAAA_AAAA);
        send_key_word(32'h5555_5555);
        for (int i = 0; i < 4; i++) send_key_word(random_word());

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: pad = 5'd23;
                1: pad = 5'd0;
                2: pad = 5'd31;
                default: pad = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                        : 5'($urandom_range(4));
            endcase
            write_pad(pad);
            quiet = (ph == 6);
            n = $urandom_range(90, 110);
            repeat (n) send_key_word(random_word());
        end
        quiet = 1'b0;
        while (tracker.words_in_run != 0) send_key_word(random_word());
        key_if.valid <= 1'b0;

        drain_crcs();
        tracker.flush_leftover();

        $display("sent %0d key words over %0d pad settings, checked %0d crc results",
                 tracker.words_seen, pad_writes + 1, tracker.crcs_checked);
        $display("%0d errors", tracker.errors);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
